// ===== design/rfid_reader_register_model_top_assert.svh =====
// Assertion macros for the register model block.
// Each macro takes a label, the clock, the reset, a condition and a check.
`ifndef RFID_READER_REGISTER_MODEL_TOP_ASSERT_SVH
`define RFID_READER_REGISTER_MODEL_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define RRM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define RRM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define RRM_ASSERT_IMP(lbl, clk, rst, ante, cons)

`define RRM_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== design/rrm_pkg.sv =====
`default_nettype none

package rrm_pkg;

  // FIFO geometry
  localparam int FIFO_DEPTH = 64;
  localparam int FIFO_IDX_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH + 1);

  // low FIFO entries kept in flops so a card answer can load them at once
  localparam int HEAD_N  = 5;
  localparam int HEAD_IW = $clog2(HEAD_N);

  localparam int REG_AW = 6;
  localparam int REG_N  = 1 << REG_AW;

  // register numbers
  localparam logic [REG_AW-1:0] R_COMMAND   = 6'h01;
  localparam logic [REG_AW-1:0] R_COMIRQ    = 6'h04;
  localparam logic [REG_AW-1:0] R_FIFODATA  = 6'h09;
  localparam logic [REG_AW-1:0] R_FIFOLEVEL = 6'h0A;
  localparam logic [REG_AW-1:0] R_CONTROL   = 6'h0C;
  localparam logic [REG_AW-1:0] R_BITFRAME  = 6'h0D;
  localparam logic [REG_AW-1:0] R_VERSION   = 6'h37;

  // command codes
  localparam logic [3:0] CMD_XCHG    = 4'hC;
  localparam logic [3:0] CMD_RESTART = 4'hF;

  // card frames
  localparam logic [7:0] FRAME_REQ     = 8'h26;
  localparam logic [7:0] FRAME_SELECT  = 8'h93;
  localparam logic [7:0] ATQA_LO       = 8'h44;
  localparam logic [7:0] ATQA_HI       = 8'h00;
  localparam int         ATQA_LEN      = 2;
  localparam int         UID_LEN       = 5;

  localparam logic [7:0] IRQ_TIMER   = 8'h01;
  localparam logic [7:0] IRQ_RX_IDLE = 8'h30;
  localparam logic [7:0] VERSION_RST = 8'h92;

  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] addr;
    logic [7:0]        data;
  } rf_wr_t;

  typedef struct packed {
    logic                  push;
    logic [FIFO_IDX_W-1:0] widx;
    logic [7:0]            wdata;
    logic                  load_atqa;
    logic                  load_uid;
    logic [31:0]           uid;
  } fifo_ctl_t;

endpackage

`default_nettype wire

// ===== design/rrm_if.sv =====
`default_nettype none

interface rrm_req_if;
  logic        valid;
  logic        ready;
  logic        frame_valid;
  logic [7:0]  address_byte;
  logic [7:0]  write_data;
  logic        card_present;
  logic [31:0] card_uid;

  modport source (output valid, frame_valid, address_byte, write_data, card_present,
                  card_uid, input ready);
  modport sink (input valid, frame_valid, address_byte, write_data, card_present,
                card_uid, output ready);
endinterface

interface rrm_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

`default_nettype wire

// ===== design/rrm_regfile.sv =====
`default_nettype none

module rrm_regfile (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire rrm_pkg::rf_wr_t           wr,
  input  wire logic                      clr,
  input  wire logic [rrm_pkg::REG_AW-1:0] rd_addr,
  input  wire logic [rrm_pkg::REG_AW-1:0] cur_addr,
  output logic      [7:0]                rd_data
);
  import rrm_pkg::*;

  logic [7:0]       mem [REG_N];
  logic [REG_N-1:0] vld;
  logic [7:0]       rd_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    // prefetch for the beat in the stage next cycle, bypassing this cycle's write
    if (wr.en && wr.addr == rd_addr) begin
      rd_q <= wr.data;
    end else begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.addr] <= 1'b1;
    end
  end

  // unwritten entries read as their reset value
  always_comb begin
    if (vld[cur_addr]) begin
      rd_data = rd_q;
    end else if (cur_addr == R_VERSION) begin
      rd_data = VERSION_RST;
    end else begin
      rd_data = '0;
    end
  end

endmodule

`default_nettype wire

// ===== design/rrm_fifo.sv =====
`default_nettype none

module rrm_fifo (
  input  wire logic                          clk,
  input  wire rrm_pkg::fifo_ctl_t            ctl,
  input  wire logic [rrm_pkg::FIFO_IDX_W-1:0] rd_idx,
  input  wire logic [rrm_pkg::FIFO_IDX_W-1:0] rd_idx_next,
  output logic      [7:0]                    rd_data,
  output logic      [7:0]                    head0
);
  import rrm_pkg::*;

  localparam logic [FIFO_IDX_W-1:0] HEAD_LIM = FIFO_IDX_W'(HEAD_N);

  logic [7:0] mem  [FIFO_DEPTH];
  logic [7:0] head [HEAD_N];
  logic [7:0] mem_q;
  logic [7:0] bcc;

  assign bcc = ctl.uid[7:0] ^ ctl.uid[15:8] ^ ctl.uid[23:16] ^ ctl.uid[31:24];

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[ctl.widx] <= ctl.wdata;
    end
    if (ctl.push && ctl.widx == rd_idx_next) begin
      mem_q <= ctl.wdata;
    end else begin
      mem_q <= mem[rd_idx_next];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_atqa) begin
      head[0] <= ATQA_LO;
      head[1] <= ATQA_HI;
    end else if (ctl.load_uid) begin
      head[0] <= ctl.uid[7:0];
      head[1] <= ctl.uid[15:8];
      head[2] <= ctl.uid[23:16];
      head[3] <= ctl.uid[31:24];
      head[4] <= bcc;
    end else if (ctl.push && ctl.widx < HEAD_LIM) begin
      head[ctl.widx[HEAD_IW-1:0]] <= ctl.wdata;
    end
  end

  assign rd_data = (rd_idx < HEAD_LIM) ? head[rd_idx[HEAD_IW-1:0]] : mem_q;
  assign head0   = head[0];

endmodule

`default_nettype wire

// ===== design/rfid_reader_register_model_top.sv =====
`default_nettype none

// Register model of a contactless reader front end. Each request beat is one
// two-byte register access (address byte bit 7 = read, bits 6..1 = register)
// and yields exactly one response beat carrying read_data (zero for writes,
// invalid frames and pops from an empty FIFO). The block takes one beat per
// clock while the response side is not back-pressured: a beat enters the
// stage register, is resolved by combinational logic against the register
// file and FIFO, and then lands in the response register.
// Back-pressure on the response side holds one beat in the stage and one in
// the response register before request ready drops. Register 0x09 is the FIFO
// port (push on write, pop on read), 0x0A its level (bit 7 written flushes),
// command 0x0F is a soft reset that restores register defaults (version 0x37
// reads 0x92), and writing bit-framing 0x0D with bit 7 set in transceive runs
// a simulated card exchange using card_present and card_uid. There is no
// clearing pass after reset; the register file resets through valid bits.
module rfid_reader_register_model_top (
  input wire logic clk,
  input wire logic rst,
  rrm_req_if.sink   req,
  rrm_rsp_if.source rsp
);
  import rrm_pkg::*;

  localparam logic [FIFO_PTR_W-1:0] FIFO_FULL = FIFO_PTR_W'(FIFO_DEPTH);

  // stage register
  logic        s1_vld;
  logic        s1_frame;
  logic [7:0]  s1_addr;
  logic [7:0]  s1_wdata;
  logic        s1_present;
  logic [31:0] s1_uid;

  // control registers kept outside the register file
  logic [3:0]            cmd, cmd_next;
  logic [7:0]            irq, irq_next;
  logic [7:0]            lvl, lvl_next;
  logic [7:0]            ctl, ctl_next;
  logic [FIFO_PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [FIFO_PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [31:0]           uid_latch, uid_next;

  logic                  req_fire;
  logic                  s1_adv;
  logic                  out_free;
  logic                  act;
  logic [REG_AW-1:0]     s1_reg;
  logic [REG_AW-1:0]     rf_rd_addr;
  logic [7:0]            rf_data;
  logic [7:0]            fifo_data;
  logic [7:0]            fifo_head0;
  logic                  restart;
  logic [7:0]            result;
  rf_wr_t                rf_wr;
  fifo_ctl_t             fifo_ctl;

  assign out_free  = !rsp.valid || rsp.ready;
  assign s1_adv    = s1_vld && out_free;
  assign req.ready = !s1_vld || s1_adv;
  assign req_fire  = req.valid && req.ready;
  assign s1_reg    = s1_addr[REG_AW:1];
  assign act       = s1_adv && s1_frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (req_fire) begin
      s1_vld <= 1'b1;
    end else if (s1_adv) begin
      s1_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_frame   <= req.frame_valid;
      s1_addr    <= req.address_byte;
      s1_wdata   <= req.write_data;
      s1_present <= req.card_present;
      s1_uid     <= req.card_uid;
    end
  end

  // register file prefetch follows whichever beat sits in the stage next cycle
  assign rf_rd_addr = req_fire ? req.address_byte[REG_AW:1] : s1_reg;

  rrm_regfile u_regfile (
    .clk      (clk),
    .rst      (rst),
    .wr       (rf_wr),
    .clr      (restart),
    .rd_addr  (rf_rd_addr),
    .cur_addr (s1_reg),
    .rd_data  (rf_data)
  );

  rrm_fifo u_fifo (
    .clk         (clk),
    .ctl         (fifo_ctl),
    .rd_idx      (rd_ptr[FIFO_IDX_W-1:0]),
    .rd_idx_next (rd_ptr_next[FIFO_IDX_W-1:0]),
    .rd_data     (fifo_data),
    .head0       (fifo_head0)
  );

  always_comb begin
    cmd_next    = cmd;
    irq_next    = irq;
    lvl_next    = lvl;
    ctl_next    = ctl;
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    uid_next    = uid_latch;
    restart     = 1'b0;
    result      = '0;
    rf_wr.en    = 1'b0;
    rf_wr.addr  = s1_reg;
    rf_wr.data  = s1_wdata;
    fifo_ctl.push      = 1'b0;
    fifo_ctl.widx      = wr_ptr[FIFO_IDX_W-1:0];
    fifo_ctl.wdata     = s1_wdata;
    fifo_ctl.load_atqa = 1'b0;
    fifo_ctl.load_uid  = 1'b0;
    fifo_ctl.uid       = uid_latch;

    if (act) begin
      if (s1_addr[7]) begin
        case (s1_reg)
          R_FIFODATA: begin
            if (rd_ptr < wr_ptr && rd_ptr < FIFO_FULL) begin
              result      = fifo_data;
              rd_ptr_next = rd_ptr + 1'b1;
              if (lvl != '0) begin
                lvl_next = lvl - 1'b1;
              end
            end
          end
          R_COMMAND:   result = {4'b0, cmd};
          R_COMIRQ:    result = irq;
          R_FIFOLEVEL: result = lvl;
          R_CONTROL:   result = ctl;
          default:     result = rf_data;
        endcase
      end else begin
        case (s1_reg)
          R_COMMAND: begin
            cmd_next = s1_wdata[3:0];
            if (s1_wdata[3:0] == CMD_RESTART) begin
              restart     = 1'b1;
              cmd_next    = '0;
              irq_next    = '0;
              lvl_next    = '0;
              ctl_next    = '0;
              wr_ptr_next = '0;
              rd_ptr_next = '0;
            end
          end
          R_FIFODATA: begin
            if (wr_ptr < FIFO_FULL) begin
              fifo_ctl.push = 1'b1;
              wr_ptr_next   = wr_ptr + 1'b1;
              lvl_next      = 8'(wr_ptr_next);
            end
          end
          R_FIFOLEVEL: begin
            if (s1_wdata[7]) begin
              wr_ptr_next = '0;
              rd_ptr_next = '0;
              lvl_next    = '0;
            end
          end
          R_COMIRQ:  irq_next = s1_wdata;
          R_CONTROL: ctl_next = s1_wdata;
          R_BITFRAME: begin
            rf_wr.en = 1'b1;
            // simulated card exchange
            if (s1_wdata[7] && cmd == CMD_XCHG) begin
              if (wr_ptr == '0) begin
                irq_next = irq | IRQ_TIMER;
              end else begin
                wr_ptr_next = '0;
                rd_ptr_next = '0;
                if (!s1_present) begin
                  irq_next = irq | IRQ_TIMER;
                end else if (fifo_head0 == FRAME_REQ) begin
                  fifo_ctl.load_atqa = 1'b1;
                  wr_ptr_next        = FIFO_PTR_W'(ATQA_LEN);
                  lvl_next           = 8'(ATQA_LEN);
                  ctl_next           = '0;
                  irq_next           = irq | IRQ_RX_IDLE;
                  uid_next           = s1_uid;
                end else if (fifo_head0 == FRAME_SELECT) begin
                  fifo_ctl.load_uid = 1'b1;
                  wr_ptr_next       = FIFO_PTR_W'(UID_LEN);
                  lvl_next          = 8'(UID_LEN);
                  ctl_next          = '0;
                  irq_next          = irq | IRQ_RX_IDLE;
                end else begin
                  irq_next = irq | IRQ_TIMER;
                end
              end
            end
          end
          default: rf_wr.en = 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd       <= '0;
      irq       <= '0;
      lvl       <= '0;
      ctl       <= '0;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      uid_latch <= '0;
    end else begin
      cmd       <= cmd_next;
      irq       <= irq_next;
      lvl       <= lvl_next;
      ctl       <= ctl_next;
      wr_ptr    <= wr_ptr_next;
      rd_ptr    <= rd_ptr_next;
      uid_latch <= uid_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (s1_adv) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp.read_data <= result;
    end
  end

`include "rfid_reader_register_model_top_assert.svh"

  `RRM_ASSERT_IMP(a_ptr_order, clk, rst, 1'b1, rd_ptr <= wr_ptr)
  `RRM_ASSERT_IMP(a_ptr_bound, clk, rst, 1'b1, wr_ptr <= FIFO_FULL)
  `RRM_ASSERT_NXT(a_push_level, clk, rst, fifo_ctl.push, lvl == 8'(wr_ptr))
  `RRM_ASSERT_IMP(a_full_stall, clk, rst, s1_vld && rsp.valid && !rsp.ready, !req.ready)

endmodule

`default_nettype wire
